### src/crcbs_pkg.sv
package crcbs_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [7:0]  FLAG_OCT = 8'h7E;

  typedef enum logic [1:0] {
    PH_IDLE,   // no frame open, next input opens one
    PH_DATA,   // payload bytes
    PH_CRC,    // four trailer bytes
    PH_CLOSE   // pad and closing flag
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // up to two output beats per core step; v1 only with v0
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_beat_t b0;
    out_beat_t b1;
  } push_t;

  // stuffed bits of one byte, left aligned, n of them valid
  typedef struct packed {
    logic [9:0] bits;
    logic [3:0] n;
    logic [2:0] run;
  } stuff_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] v);
    logic [31:0] c;
    c = c_in ^ {24'd0, v};
    for (int j = 0; j < 8; j++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // MSB first, zero after each fifth one in a row
  function automatic stuff_t stuff_byte(input logic [7:0] v, input logic [2:0] run_in);
    stuff_t     r;
    logic [2:0] run;
    logic [3:0] pos;
    r.bits = '0;
    run    = run_in;
    pos    = '0;
    for (int i = 7; i >= 0; i--) begin
      r.bits[4'd9 - pos] = v[i];
      pos = pos + 4'd1;
      if (v[i]) begin
        run = run + 3'd1;
      end else begin
        run = '0;
      end
      if (run == 3'd5) begin
        pos = pos + 4'd1;
        run = '0;
      end
    end
    r.n   = pos;
    r.run = run;
    return r;
  endfunction

endpackage

### src/crc32_bit_stuffed_framer.sv
// HDLC-style framer with CRC-32 trailer and zero-bit stuffing.
//
// Slave side (s_*): payload bytes, s_tlast on the final byte of a frame.
// Master side (m_*): framed byte stream. Each frame is 0x7E, the stuffed
// payload, the stuffed CRC-32 (reflected, init all ones, inverted, sent
// low byte first, MSB first), zero padding of a partial byte, then 0x7E
// with m_tlast high.
//
// Each byte passes the input register and the output queue. The opening
// flag is pushed in the step that sees the first byte of a frame, that
// byte's beats in the step after. The core takes one step per cycle while
// the output queue has room, one input byte per payload step, giving 1 to
// 2 beats each. The master port drains one beat per cycle while m_tready
// is high. Per frame add one step for the opening flag, four for the
// trailer and one for pad plus closing flag.
// A beat is only pushed when the output queue has room for two, so a
// stalled receiver holds the core; the input register keeps accepting
// while the core consumes its byte, and s_tready falls once it is full and held.
// Reset (rst, synchronous) empties the queue and the input register and
// leaves the framer idle, waiting to open a frame.
module crc32_bit_stuffed_framer #(
  parameter int FIFO_DEPTH = 4   // output queue beats, at least 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] data_byte
  input  logic       s_tlast,    // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_byte
  output logic       m_tlast     // end_of_frame
);
  import crcbs_pkg::*;

  in_beat_t in_reg;
  logic     take;
  logic     room_ok;
  push_t    push;

  // input register, refilled in the cycle the core consumes it
  assign s_tready = !in_reg.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg.valid <= 1'b0;
    end else if (s_tready) begin
      in_reg.valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_reg.data <= s_tdata;
      in_reg.last <= s_tlast;
    end
  end

  crcbs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .in_beat (in_reg),
    .room_ok (room_ok),
    .take    (take),
    .push    (push)
  );

  crcbs_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room_ok  (room_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  a_eof_is_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tdata == FLAG_OCT)
    else $error("frame end beat is not a flag");
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> in_reg.valid && room_ok)
    else $error("core consumed an empty input register");
`endif

endmodule

### src/crcbs_out_fifo.sv
module crcbs_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  crcbs_pkg::push_t    push,
  output logic                room_ok,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // out_byte
  output logic                m_tlast    // end_of_frame
);
  import crcbs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  out_beat_t        mem [DEPTH];
  logic [PW-1:0]    wp, rp;
  logic [CW-1:0]    count;
  logic [PW-1:0]    wp1, wp2, rp1;
  logic [CW-1:0]    count_next;
  logic             rd;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wp1 = inc(wp);
  assign wp2 = inc(wp1);
  assign rp1 = inc(rp);

  assign rd       = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign m_tdata  = mem[rp].data;
  assign m_tlast  = mem[rp].last;
  assign room_ok  = (count <= CW'(DEPTH - 2));

  assign count_next = count + CW'(push.v0) + CW'(push.v1) - CW'(rd);

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wp] <= push.b0;
    end
    if (push.v1) begin
      mem[wp1] <= push.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (rd) begin
        rp <= rp1;
      end
      if (push.v1) begin
        wp <= wp2;
      end else if (push.v0) begin
        wp <= wp1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("output queue overflow");
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> $past(count_next) == count && count <= CW'(DEPTH - 2))
    else $error("beats pushed without room");
`endif

endmodule

### src/crcbs_core.sv
module crcbs_core (
  input  logic                 clk,
  input  logic                 rst,
  input  crcbs_pkg::in_beat_t  in_beat,
  input  logic                 room_ok,
  output logic                 take,
  output crcbs_pkg::push_t     push
);
  import crcbs_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] crc, crc_next;
  logic [2:0]  ones, ones_next;
  logic [7:0]  acc, acc_next;     // pending bits, left aligned, zeros below
  logic [2:0]  held, held_next;
  logic [1:0]  idx, idx_next;     // trailer byte index

  logic [31:0] crc_upd;
  logic [31:0] fin;
  logic [7:0]  sel;
  stuff_t      sres;
  logic [23:0] win;
  logic [4:0]  total;
  logic        step;

  assign crc_upd = crc_byte(crc, in_beat.data);
  assign fin     = ~crc;
  assign sel     = (phase == PH_CRC) ? fin[{idx, 3'b000} +: 8] : in_beat.data;
  assign sres    = stuff_byte(sel, ones);
  assign win     = {acc, 16'd0} | ({sres.bits, 14'd0} >> held);
  assign total   = {2'b00, held} + {1'b0, sres.n};

  always_comb begin
    unique case (phase)
      PH_IDLE, PH_DATA: step = room_ok && in_beat.valid;
      default:          step = room_ok;
    endcase
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        PH_IDLE:  phase_next = PH_DATA;
        PH_DATA:  phase_next = in_beat.last ? PH_CRC : PH_DATA;
        PH_CRC:   phase_next = (idx == 2'd3) ? PH_CLOSE : PH_CRC;
        PH_CLOSE: phase_next = PH_IDLE;
      endcase
    end
  end

  // datapath and pushes
  always_comb begin
    take      = 1'b0;
    push      = '0;
    crc_next  = crc;
    ones_next = ones;
    acc_next  = acc;
    held_next = held;
    idx_next  = idx;
    if (step) begin
      unique case (phase)
        PH_IDLE: begin
          push.v0   = 1'b1;
          push.b0   = '{data: FLAG_OCT, last: 1'b0};
          crc_next  = CRC_INIT;
          ones_next = '0;
          acc_next  = '0;
          held_next = '0;
        end
        PH_DATA, PH_CRC: begin
          if (phase == PH_DATA) begin
            take     = 1'b1;
            crc_next = crc_upd;
            idx_next = '0;
          end else begin
            idx_next = idx + 2'd1;
          end
          ones_next = sres.run;
          push.b0   = '{data: win[23:16], last: 1'b0};
          push.b1   = '{data: win[15:8], last: 1'b0};
          if (total >= 5'd16) begin
            push.v0   = 1'b1;
            push.v1   = 1'b1;
            acc_next  = win[7:0];
            held_next = 3'(total - 5'd16);
          end else if (total >= 5'd8) begin
            push.v0   = 1'b1;
            acc_next  = win[15:8];
            held_next = 3'(total - 5'd8);
          end else begin
            acc_next  = win[23:16];
            held_next = total[2:0];
          end
        end
        PH_CLOSE: begin
          push.v0 = 1'b1;
          if (held != '0) begin
            push.v1 = 1'b1;
            push.b0 = '{data: acc, last: 1'b0};
            push.b1 = '{data: FLAG_OCT, last: 1'b1};
          end else begin
            push.b0 = '{data: FLAG_OCT, last: 1'b1};
          end
          crc_next  = CRC_INIT;
          ones_next = '0;
          acc_next  = '0;
          held_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      crc   <= CRC_INIT;
      ones  <= '0;
      acc   <= '0;
      held  <= '0;
      idx   <= '0;
    end else begin
      phase <= phase_next;
      crc   <= crc_next;
      ones  <= ones_next;
      acc   <= acc_next;
      held  <= held_next;
      idx   <= idx_next;
    end
  end

`ifndef SYNTH
  a_run_short: assert property (@(posedge clk) disable iff (rst)
    ones < 3'd5)
    else $error("ones run reached stuffing point without a zero");
  a_close_to_idle: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CLOSE && step) |=> phase == PH_IDLE && held == '0)
    else $error("frame close did not return to idle");
`endif

endmodule
